// File: src/rnlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnlp_pkg
// Shared types, character codes and helper functions for the radix number
// literal parser.
// ----------------------------------------------------------------------------
package rnlp_pkg;

  // Parser phase
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,  // skipping blanks, sign allowed
    PH_SIGNED = 2'd1,  // sign seen, prefix or first digit due
    PH_FIRST  = 2'd2,  // prefix seen, first digit due
    PH_DIGITS = 2'd3   // collecting further digits
  } rnlp_phase_e;

  // Radix selection
  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_BIN = 2'd1,
    RADIX_HEX = 2'd2
  } rnlp_radix_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_FIRST = 2'd1,
    ST_TOO_MANY  = 2'd2,
    ST_RANGE     = 2'd3
  } rnlp_status_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_MIN = 1'b0,
    CFG_MAX = 1'b1
  } rnlp_cfg_e;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned LeftWidth   = 5;
  localparam int unsigned DigitWidth  = 5;

  localparam logic [ValueWidth-1:0] MinReset = 32'hFFFF_D8F0;  // -10000
  localparam logic [ValueWidth-1:0] MaxReset = 32'h0000_2710;  //  10000

  // Digits still allowed after the first one
  localparam logic [LeftWidth-1:0] ExtraDec = 5'd9;
  localparam logic [LeftWidth-1:0] ExtraBin = 5'd31;
  localparam logic [LeftWidth-1:0] ExtraHex = 5'd7;

  localparam logic [DigitWidth-1:0] NoDigit = 5'd16;

  // Character codes
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChLowB  = 8'h62;
  localparam logic [7:0] ChUpB   = 8'h42;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChUscore = 8'h5F;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;

  // Literal state carried between characters
  typedef struct packed {
    rnlp_phase_e                phase;
    logic                       negative;
    rnlp_radix_e                radix;
    logic [LeftWidth-1:0]       digits_left;
    logic [ValueWidth-1:0]      acc;
  } rnlp_state_t;

  localparam rnlp_state_t StateReset = '{
    phase:       PH_IDLE,
    negative:    1'b0,
    radix:       RADIX_DEC,
    digits_left: '0,
    acc:         '0
  };

  // One finished literal
  typedef struct packed {
    logic                  emit;
    logic [ValueWidth-1:0] value;
    rnlp_status_e          status;
  } rnlp_result_t;

  // Digit value of a character, NoDigit if none
  function automatic logic [DigitWidth-1:0] digit_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= ChZero && c <= ChNine) begin
      t = c - ChZero;
    end else if (c >= ChUpA && c <= ChUpF) begin
      t = c - ChUpA + 8'd10;
    end else if (c >= ChLowA && c <= ChLowF) begin
      t = c - ChLowA + 8'd10;
    end else begin
      t = {3'b000, NoDigit};
    end
    return t[DigitWidth-1:0];
  endfunction

  // True if the digit is valid in the radix
  function automatic logic digit_ok(input logic [DigitWidth-1:0] d,
                                    input rnlp_radix_e r);
    logic ok;
    unique case (r)
      RADIX_BIN: ok = (d < 5'd2);
      RADIX_HEX: ok = (d < 5'd16);
      RADIX_DEC: ok = (d < 5'd10);
      default:   ok = (d < 5'd10);
    endcase
    return ok;
  endfunction

  // Digit budget that follows the first digit
  function automatic logic [LeftWidth-1:0] extra_of(input rnlp_radix_e r);
    logic [LeftWidth-1:0] e;
    unique case (r)
      RADIX_BIN: e = ExtraBin;
      RADIX_HEX: e = ExtraHex;
      RADIX_DEC: e = ExtraDec;
      default:   e = ExtraDec;
    endcase
    return e;
  endfunction

endpackage

// File: src/radix_number_literal_parser.sv
`timescale 1ns / 1ps
// A character accepted is held in the input register and decoded from it once the
// result register can take a beat; a result it causes is held in the result register.
// Throughput: one character per cycle, limited only by output stall.
// Reset (rst_ni low, asynchronous) empties both registers, returns the
// parser to idle and loads min/max with -10000 and 10000.
// ----------------------------------------------------------------------------
// radix_number_literal_parser
// Streaming ASCII integer literal parser with binary/hex prefixes, underscore
// separators, digit budget and a configurable signed range check.
// ----------------------------------------------------------------------------
module radix_number_literal_parser
  import rnlp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // character input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            ch_i,
  // result output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [31:0]    value_o,
  output logic [1:0]            status_o,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_index_i,
  input  logic signed [31:0]    cfg_data_i
);

  logic                  in_valid_q;
  logic [7:0]            ch_q;
  rnlp_state_t           state_q, state_d;
  rnlp_result_t          step_res;
  logic [ValueWidth-1:0] min_q, max_q;
  logic                  out_valid_q, out_valid_d;
  logic [ValueWidth-1:0] value_q;
  rnlp_status_e          status_q;
  logic                  step_fire;
  logic                  in_take;

  // A buffered character is decoded when the result register can take a beat
  assign step_fire  = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step_fire;
  assign in_take    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MinReset;
      max_q <= MaxReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (rnlp_cfg_e'(cfg_index_i))
        CFG_MIN: min_q <= cfg_data_i;
        CFG_MAX: max_q <= cfg_data_i;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ch_q <= ch_i;
    end
  end

  // Per-character decode
  rnlp_step u_step (
    .state_i  (state_q),
    .ch_i     (ch_q),
    .min_i    (min_q),
    .max_i    (max_q),
    .state_o  (state_d),
    .result_o (step_res)
  );

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (step_fire && step_res.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire && step_res.emit) begin
      value_q  <= step_res.value;
      status_q <= step_res.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  // A stalled input means a buffered character is waiting
  a_stall_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  // A result always returns the parser to idle
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && step_res.emit) |=> (state_q.phase == PH_IDLE && state_q.acc == '0))
    else $error("parser not idle after a result");

  // An ok beat lies inside the configured range
  a_ok_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_OK)
      |-> ($signed(value_q) >= $signed(min_q) && $signed(value_q) <= $signed(max_q)))
    else $error("ok result outside range");

  // A bad first digit carries value zero
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_BAD_FIRST) |-> (value_q == '0))
    else $error("bad-first result with nonzero value");

  // Hex budget never exceeds seven further digits
  a_hex_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.radix == RADIX_HEX) |-> (state_q.digits_left <= ExtraHex))
    else $error("hex digit budget overrun");
`endif

endmodule

// File: src/rnlp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnlp_step
// Combinational next-state and result logic for one character: sign and
// prefix decode, shift-add digit accumulation and range check.
// ----------------------------------------------------------------------------
module rnlp_step
  import rnlp_pkg::*;
(
  input  rnlp_state_t           state_i,
  input  logic [7:0]            ch_i,
  input  logic [ValueWidth-1:0] min_i,
  input  logic [ValueWidth-1:0] max_i,
  output rnlp_state_t           state_o,
  output rnlp_result_t          result_o
);

  logic [DigitWidth-1:0] dig;
  logic                  dig_ok;
  logic                  blank;
  logic                  is_sign;
  logic [ValueWidth-1:0] acc_next;
  logic [ValueWidth-1:0] signed_val;
  logic                  out_of_range;

  assign dig     = digit_of(ch_i);
  assign dig_ok  = digit_ok(dig, state_i.radix);
  assign blank   = (ch_i == ChSpace) || (ch_i == ChTab);
  assign is_sign = (ch_i == ChMinus) || (ch_i == ChPlus);

  // acc * radix + digit, as shifts and adds (two adds for decimal)
  always_comb begin
    unique case (state_i.radix)
      RADIX_BIN: acc_next = {state_i.acc[ValueWidth-2:0], 1'b0};
      RADIX_HEX: acc_next = {state_i.acc[ValueWidth-5:0], 4'b0000};
      RADIX_DEC: acc_next = {state_i.acc[ValueWidth-4:0], 3'b000}
                          + {state_i.acc[ValueWidth-2:0], 1'b0};
      default:   acc_next = {state_i.acc[ValueWidth-4:0], 3'b000}
                          + {state_i.acc[ValueWidth-2:0], 1'b0};
    endcase
    acc_next = acc_next + {{(ValueWidth-DigitWidth){1'b0}}, dig};
  end

  // Signed value and range check of the current literal
  assign signed_val   = state_i.negative ? (~state_i.acc + 32'd1) : state_i.acc;
  assign out_of_range = ($signed(signed_val) < $signed(min_i))
                     || ($signed(max_i) < $signed(signed_val));

  // Next state and result
  always_comb begin
    state_o         = state_i;
    result_o.emit   = 1'b0;
    result_o.value  = '0;
    result_o.status = ST_OK;

    unique case (state_i.phase)
      PH_IDLE, PH_SIGNED: begin
        if (state_i.phase == PH_IDLE && blank) begin
          // leading blank, skip
        end else if (state_i.phase == PH_IDLE && is_sign) begin
          state_o.negative = (ch_i == ChMinus);
          state_o.phase    = PH_SIGNED;
        end else if (ch_i == ChLowB || ch_i == ChUpB) begin
          state_o.radix = RADIX_BIN;
          state_o.phase = PH_FIRST;
        end else if (ch_i == ChDollar) begin
          state_o.radix = RADIX_HEX;
          state_o.phase = PH_FIRST;
        end else if (dig < 5'd10) begin
          state_o.radix       = RADIX_DEC;
          state_o.acc         = {{(ValueWidth-DigitWidth){1'b0}}, dig};
          state_o.digits_left = ExtraDec;
          state_o.phase       = PH_DIGITS;
        end else begin
          result_o.emit   = 1'b1;
          result_o.status = ST_BAD_FIRST;
        end
      end
      PH_FIRST: begin
        if (dig_ok) begin
          state_o.acc         = {{(ValueWidth-DigitWidth){1'b0}}, dig};
          state_o.digits_left = extra_of(state_i.radix);
          state_o.phase       = PH_DIGITS;
        end else begin
          result_o.emit   = 1'b1;
          result_o.status = ST_BAD_FIRST;
        end
      end
      PH_DIGITS: begin
        if (state_i.digits_left != '0 && ch_i == ChUscore) begin
          // separator, ignored
        end else if (state_i.digits_left != '0 && dig_ok) begin
          state_o.acc         = acc_next;
          state_o.digits_left = state_i.digits_left - 5'd1;
        end else begin
          result_o.emit  = 1'b1;
          result_o.value = signed_val;
          if (dig_ok) begin
            result_o.status = ST_TOO_MANY;
          end else if (out_of_range) begin
            result_o.status = ST_RANGE;
          end else begin
            result_o.status = ST_OK;
          end
        end
      end
    endcase

    // every result starts a fresh literal
    if (result_o.emit) begin
      state_o = StateReset;
    end
  end

endmodule
